// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker of the transmit queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define RLTQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define RLTQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/rltq_pkg.sv -----
// Types and constants of the rate limited transmit queue.
package rltq_pkg;

    localparam int SUB_ID_W = 16;
    localparam int RECV_W   = 16;
    localparam int PLEN_W   = 8;
    localparam int HANDLE_W = 8;
    localparam int TIME_W   = 32;
    localparam int STORED_W = 9;
    localparam int FLEN_W   = 10;
    localparam int SEQ_W    = 8;
    localparam int LIMIT_W  = 16;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_QUEUED   = 3'd0,
        ST_TOO_LONG = 3'd1,
        ST_FULL     = 3'd2,
        ST_BAD_SUB  = 3'd3,
        ST_SENT     = 3'd4,
        ST_IDLE     = 3'd5,
        ST_DEFERRED = 3'd6,
        ST_DROPPED  = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        REG_SENTRY_MODE  = 3'd0,
        REG_LIMIT_NORMAL = 3'd1,
        REG_LIMIT_SENTRY = 3'd2,
        REG_MIN_GAP      = 3'd3,
        REG_MAX_USER_LEN = 3'd4,
        REG_SUB_ID_MIN   = 3'd5,
        REG_SUB_ID_MAX   = 3'd6,
        REG_FRAME_MAX    = 3'd7
    } reg_idx_t;

    localparam logic [LIMIT_W-1:0]  RST_LIMIT_NORMAL = 16'd3720;
    localparam logic [LIMIT_W-1:0]  RST_LIMIT_SENTRY = 16'd3720;
    localparam logic [15:0]         RST_MIN_GAP      = 16'd34;
    localparam logic [PLEN_W-1:0]   RST_MAX_USER_LEN = 8'd113;
    localparam logic [SUB_ID_W-1:0] RST_SUB_ID_MIN   = 16'd512;
    localparam logic [SUB_ID_W-1:0] RST_SUB_ID_MAX   = 16'd767;
    localparam logic [8:0]          RST_FRAME_MAX    = 9'd128;

    typedef struct packed {
        logic [SUB_ID_W-1:0] sub_id;
        logic [RECV_W-1:0]   receiver;
        logic [STORED_W-1:0] stored_len;
        logic [HANDLE_W-1:0] handle;
    } slot_t;

endpackage

// ----- hdl/rate_limited_tx_queue_unit.sv -----
// Rate limited transmit queue: message ring with send spacing and byte window budget.
// An accepted item passes the input stage register and then the result stage register that drives done.
// Throughput: one item per cycle; busy stays low, the head entry is prefetched
// from the queue memory into a register so every item finishes in one pass.
// Reset clears pointers, window state, sequence count and configuration;
// the queue memory itself is not cleared.
module rate_limited_tx_queue_unit
    import rltq_pkg::*;
#(
    parameter int QUEUE_SLOTS    = 16,
    parameter int HEADER_BYTES   = 6,
    parameter int FRAME_OVERHEAD = 9,
    parameter int WINDOW_MS      = 1000
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                start,
    output logic                busy,
    input  logic                op,
    input  logic [SUB_ID_W-1:0] sub_id,
    input  logic [RECV_W-1:0]   receiver,
    input  logic [PLEN_W-1:0]   payload_len,
    input  logic [HANDLE_W-1:0] payload_handle,
    input  logic [TIME_W-1:0]   now_ms,
    output logic                done,
    output logic [2:0]          status,
    output logic [HANDLE_W-1:0] out_handle,
    output logic [SUB_ID_W-1:0] out_sub_id,
    output logic [RECV_W-1:0]   out_receiver,
    output logic [8:0]          frame_len,
    output logic [SEQ_W-1:0]    frame_seq
);

    localparam int PTR_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_SLOTS - 1);

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        n = (p == LAST_SLOT) ? '0 : p + 1'b1;
        return n;
    endfunction

    // Configuration registers.
    logic                sentry_mode_reg;
    logic [LIMIT_W-1:0]  limit_normal_reg;
    logic [LIMIT_W-1:0]  limit_sentry_reg;
    logic [15:0]         min_gap_reg;
    logic [PLEN_W-1:0]   max_user_len_reg;
    logic [SUB_ID_W-1:0] sub_id_min_reg;
    logic [SUB_ID_W-1:0] sub_id_max_reg;
    logic [8:0]          frame_max_reg;

    // Input stage.
    logic                item_valid_reg;
    logic                op_reg;
    logic [SUB_ID_W-1:0] sub_id_reg;
    logic [RECV_W-1:0]   receiver_reg;
    logic [PLEN_W-1:0]   plen_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [TIME_W-1:0]   now_reg;

    // Queue and scheduler state.
    slot_t               queue_mem [QUEUE_SLOTS];
    slot_t               head_entry_reg;
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic [TIME_W-1:0]   window_bytes_reg, window_bytes_next;
    logic [TIME_W-1:0]   window_start_reg, window_start_next;
    logic [TIME_W-1:0]   last_send_reg, last_send_next;
    logic [SEQ_W-1:0]    seq_reg, seq_next;

    // Result stage.
    logic                done_reg;
    status_t             status_reg, status_next;
    logic [HANDLE_W-1:0] out_handle_reg, out_handle_next;
    logic [SUB_ID_W-1:0] out_sub_id_reg, out_sub_id_next;
    logic [RECV_W-1:0]   out_receiver_reg, out_receiver_next;
    logic [8:0]          frame_len_reg, frame_len_next;
    logic [SEQ_W-1:0]    frame_seq_reg, frame_seq_next;

    logic                cfg_wr;
    logic [2:0]          cfg_idx;
    logic                accept;
    logic                wr_en;
    slot_t               wr_data;
    slot_t               push_slot;
    logic [LIMIT_W-1:0]  limit;
    logic                queue_full;
    logic                queue_empty;
    logic [TIME_W-1:0]   window_age;
    logic                window_restart;
    logic [TIME_W-1:0]   window_bytes_eff;
    logic [TIME_W-1:0]   gap;
    logic                too_soon;
    logic [TIME_W:0]     budget_sum;
    logic                over_budget;
    logic [FLEN_W-1:0]   flen;
    logic                frame_too_long;
    logic                len_bad;
    logic                sub_bad;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sentry_mode_reg  <= 1'b0;
            limit_normal_reg <= RST_LIMIT_NORMAL;
            limit_sentry_reg <= RST_LIMIT_SENTRY;
            min_gap_reg      <= RST_MIN_GAP;
            max_user_len_reg <= RST_MAX_USER_LEN;
            sub_id_min_reg   <= RST_SUB_ID_MIN;
            sub_id_max_reg   <= RST_SUB_ID_MAX;
            frame_max_reg    <= RST_FRAME_MAX;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(cfg_idx))
                REG_SENTRY_MODE:  sentry_mode_reg  <= pwdata[0];
                REG_LIMIT_NORMAL: limit_normal_reg <= pwdata[LIMIT_W-1:0];
                REG_LIMIT_SENTRY: limit_sentry_reg <= pwdata[LIMIT_W-1:0];
                REG_MIN_GAP:      min_gap_reg      <= pwdata[15:0];
                REG_MAX_USER_LEN: max_user_len_reg <= pwdata[PLEN_W-1:0];
                REG_SUB_ID_MIN:   sub_id_min_reg   <= pwdata[SUB_ID_W-1:0];
                REG_SUB_ID_MAX:   sub_id_max_reg   <= pwdata[SUB_ID_W-1:0];
                REG_FRAME_MAX:    frame_max_reg    <= pwdata[8:0];
                default:          sentry_mode_reg  <= sentry_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(cfg_idx))
            REG_SENTRY_MODE:  prdata = {31'd0, sentry_mode_reg};
            REG_LIMIT_NORMAL: prdata = {16'd0, limit_normal_reg};
            REG_LIMIT_SENTRY: prdata = {16'd0, limit_sentry_reg};
            REG_MIN_GAP:      prdata = {16'd0, min_gap_reg};
            REG_MAX_USER_LEN: prdata = {24'd0, max_user_len_reg};
            REG_SUB_ID_MIN:   prdata = {16'd0, sub_id_min_reg};
            REG_SUB_ID_MAX:   prdata = {16'd0, sub_id_max_reg};
            REG_FRAME_MAX:    prdata = {23'd0, frame_max_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= op;
            sub_id_reg   <= sub_id;
            receiver_reg <= receiver;
            plen_reg     <= payload_len;
            handle_reg   <= payload_handle;
            now_reg      <= now_ms;
        end
    end

    assign limit       = sentry_mode_reg ? limit_sentry_reg : limit_normal_reg;
    assign queue_full  = (next_ptr(tail_reg) == head_reg);
    assign queue_empty = (head_reg == tail_reg);

    assign window_age       = now_reg - window_start_reg;
    assign window_restart   = (window_age >= TIME_W'(WINDOW_MS));
    assign window_bytes_eff = window_restart ? '0 : window_bytes_reg;
    assign gap              = now_reg - last_send_reg;
    assign too_soon         = (gap < {16'd0, min_gap_reg});

    assign budget_sum = {1'b0, window_bytes_eff} + (TIME_W+1)'(head_entry_reg.stored_len);
    assign over_budget = (budget_sum > (TIME_W+1)'(limit));
    assign flen = FLEN_W'(FRAME_OVERHEAD) + {1'b0, head_entry_reg.stored_len};
    assign frame_too_long = (flen > {1'b0, frame_max_reg});

    assign len_bad = (plen_reg > max_user_len_reg);
    assign sub_bad = (sub_id_reg < sub_id_min_reg) || (sub_id_reg > sub_id_max_reg);

    assign push_slot.sub_id     = sub_id_reg;
    assign push_slot.receiver   = receiver_reg;
    assign push_slot.stored_len = STORED_W'(HEADER_BYTES) + {1'b0, plen_reg};
    assign push_slot.handle     = handle_reg;

    always_comb
    begin
        head_next         = head_reg;
        tail_next         = tail_reg;
        window_bytes_next = window_bytes_reg;
        window_start_next = window_start_reg;
        last_send_next    = last_send_reg;
        seq_next          = seq_reg;
        wr_en             = 1'b0;
        wr_data           = push_slot;
        status_next       = ST_QUEUED;
        out_handle_next   = '0;
        out_sub_id_next   = '0;
        out_receiver_next = '0;
        frame_len_next    = '0;
        frame_seq_next    = '0;

        if (item_valid_reg)
        begin
            if (op_reg == OP_PUSH)
            begin
                if (len_bad)
                begin
                    status_next = ST_TOO_LONG;
                end
                else if (sub_bad)
                begin
                    status_next = ST_BAD_SUB;
                end
                else if (queue_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en       = 1'b1;
                    tail_next   = next_ptr(tail_reg);
                    status_next = ST_QUEUED;
                end
            end
            else
            begin
                if (window_restart)
                begin
                    window_bytes_next = '0;
                    window_start_next = now_reg;
                end
                if (too_soon || queue_empty)
                begin
                    status_next = ST_IDLE;
                end
                else
                begin
                    head_next = next_ptr(head_reg);
                    if (over_budget)
                    begin
                        // The head entry goes back to the rear of the ring.
                        wr_en       = 1'b1;
                        wr_data     = head_entry_reg;
                        tail_next   = next_ptr(tail_reg);
                        status_next = ST_DEFERRED;
                    end
                    else
                    begin
                        last_send_next = now_reg;
                        if (frame_too_long)
                        begin
                            status_next = ST_DROPPED;
                        end
                        else
                        begin
                            window_bytes_next = window_bytes_eff + TIME_W'(flen);
                            seq_next          = seq_reg + 1'b1;
                            status_next       = ST_SENT;
                            out_handle_next   = head_entry_reg.handle;
                            out_sub_id_next   = head_entry_reg.sub_id;
                            out_receiver_next = head_entry_reg.receiver;
                            frame_len_next    = flen[8:0];
                            frame_seq_next    = seq_reg;
                        end
                    end
                end
            end
        end
    end

    // The register after the memory always holds the entry at the next head;
    // a write to that same slot in this cycle is forwarded.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            queue_mem[tail_reg] <= wr_data;
        end
        if (wr_en && (tail_reg == head_next))
        begin
            head_entry_reg <= wr_data;
        end
        else
        begin
            head_entry_reg <= queue_mem[head_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg         <= '0;
            tail_reg         <= '0;
            window_bytes_reg <= '0;
            window_start_reg <= '0;
            last_send_reg    <= '0;
            seq_reg          <= '0;
            done_reg         <= 1'b0;
            status_reg       <= ST_QUEUED;
            out_handle_reg   <= '0;
            out_sub_id_reg   <= '0;
            out_receiver_reg <= '0;
            frame_len_reg    <= '0;
            frame_seq_reg    <= '0;
        end
        else
        begin
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            window_bytes_reg <= window_bytes_next;
            window_start_reg <= window_start_next;
            last_send_reg    <= last_send_next;
            seq_reg          <= seq_next;
            done_reg         <= item_valid_reg;
            status_reg       <= status_next;
            out_handle_reg   <= out_handle_next;
            out_sub_id_reg   <= out_sub_id_next;
            out_receiver_reg <= out_receiver_next;
            frame_len_reg    <= frame_len_next;
            frame_seq_reg    <= frame_seq_next;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign out_handle   = out_handle_reg;
    assign out_sub_id   = out_sub_id_reg;
    assign out_receiver = out_receiver_reg;
    assign frame_len    = frame_len_reg;
    assign frame_seq    = frame_seq_reg;

endmodule

// ----- hdl/rltq_checker.sv -----
// Port level checker for the rate limited transmit queue, bound to the top level.
`include "assert_macros.svh"

module rltq_checker
    import rltq_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                op,
    input logic                done,
    input logic [2:0]          status,
    input logic [HANDLE_W-1:0] out_handle,
    input logic [SUB_ID_W-1:0] out_sub_id,
    input logic [RECV_W-1:0]   out_receiver,
    input logic [8:0]          frame_len,
    input logic [SEQ_W-1:0]    frame_seq
);

    // Every accepted transfer yields exactly one result.
    `RLTQ_ASSERT(a_one_result, clk, rst_n, done == $past(start && !busy && rst_n, 2), "result count mismatch")

    // Push transfers report queue outcomes, tick transfers report scheduler outcomes.
    `RLTQ_ASSERT(a_status_class, clk, rst_n, done |-> ($past(op, 2) == (status >= ST_SENT)), "status class does not match item kind")

    // Only a sent frame carries message fields.
    `RLTQ_ASSERT(a_fields_zero, clk, rst_n, (done && (status != ST_SENT)) |-> ((out_handle == 0) && (out_sub_id == 0) && (out_receiver == 0) && (frame_len == 0) && (frame_seq == 0)), "fields set on a result that is not a send")

    // Result ports rest at zero between strobes, also during reset.
    `RLTQ_ASSERT_ALWAYS(a_quiet_outputs, clk, !done |-> ((status == 0) && (frame_len == 0) && (frame_seq == 0)), "result ports active without strobe")

endmodule

bind rate_limited_tx_queue_unit rltq_checker u_rltq_checker (.*);
